// ----- src/tevq_pkg.sv -----
// shared types and constants of the timed event release queue
package tevq_pkg;

  localparam int unsigned MAX_OUT = 16;

  localparam logic [1:0] REQ_ADD   = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_START = 2'd2;

  localparam logic KIND_RELEASE = 1'b0;
  localparam logic KIND_REJECT  = 1'b1;

  typedef enum logic [1:0] {
    OP_ADD   = 2'd0,
    OP_TICK  = 2'd1,
    OP_START = 2'd2
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [15:0] id;
    logic [31:0] start_time;
    logic [30:0] elapsed;
  } cmd_t;

endpackage

// ----- src/tevq_ram.sv -----
// generic single write port ram with registered read
module tevq_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/tevq_front.sv -----
// front end: accepts requests, classifies them and queues commands
module tevq_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [79:0]       in_tdata,
  input  logic [1:0]        in_tuser,
  output logic              cmd_valid,
  output tevq_pkg::cmd_t    cmd,
  input  logic              cmd_pop
);

  tevq_pkg::cmd_t q_r [2];
  logic           wr_ptr_r, wr_ptr_nxt;
  logic           rd_ptr_r, rd_ptr_nxt;
  logic [1:0]     count_r, count_nxt;
  logic           push;
  logic           do_pop;
  tevq_pkg::cmd_t new_cmd;

  assign in_tready = (count_r != 2'd2);
  assign cmd_valid = (count_r != 2'd0);
  assign cmd       = q_r[rd_ptr_r];
  assign do_pop    = cmd_pop && cmd_valid;

  always_comb begin
    push               = 1'b0;
    new_cmd.op         = tevq_pkg::OP_ADD;
    new_cmd.id         = in_tdata[15:0];
    new_cmd.start_time = in_tdata[47:16];
    new_cmd.elapsed    = in_tdata[78:48];
    unique case (in_tuser)
      tevq_pkg::REQ_ADD: begin
        push       = in_tvalid && in_tready;
        new_cmd.op = tevq_pkg::OP_ADD;
      end
      tevq_pkg::REQ_TICK: begin
        push       = in_tvalid && in_tready;
        new_cmd.op = tevq_pkg::OP_TICK;
      end
      tevq_pkg::REQ_START: begin
        push       = in_tvalid && in_tready;
        new_cmd.op = tevq_pkg::OP_START;
      end
      default: begin
        push = 1'b0;
      end
    endcase
  end

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= new_cmd;
    end
  end

endmodule

// ----- src/tevq_back.sv -----
// back end: event queue, running time, release sequencer and output register
module tevq_back #(
  parameter int unsigned DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cmd_valid,
  input  tevq_pkg::cmd_t cmd,
  output logic           cmd_pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata,
  output logic           out_tlast,
  output logic [0:0]     out_tuser
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(tevq_pkg::MAX_OUT + 1);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_READ   = 4'b0010,
    ST_CHECK  = 4'b0100,
    ST_FINISH = 4'b1000
  } state_t;

  state_t      state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [AW-1:0] tail_r, tail_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic [30:0] rt_r, rt_nxt;
  logic [NW-1:0] n_r, n_nxt;
  logic        pend_v_r, pend_v_nxt;
  logic [15:0] pend_id_r, pend_id_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [15:0] out_id_r;
  logic        out_kind_r;
  logic        out_last_r;

  logic        emit;
  logic [15:0] emit_id;
  logic        emit_kind;
  logic        emit_last;
  logic        out_free;
  logic        ram_we;
  logic [47:0] ram_rdata;
  logic [31:0] rd_time;
  logic [15:0] rd_id;
  logic [31:0] tick_sum;
  logic        time_lt;

  tevq_ram #(
    .WIDTH(48),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(tail_r),
    .wdata({cmd.start_time, cmd.id}),
    .raddr(head_r),
    .rdata(ram_rdata)
  );

  assign rd_time  = ram_rdata[47:16];
  assign rd_id    = ram_rdata[15:0];
  assign time_lt  = rd_time[31] || (rd_time[30:0] < rt_r);
  assign tick_sum = {1'b0, rt_r} + {1'b0, cmd.elapsed};
  assign out_free = !out_valid_r || out_tready;

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_id_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_kind_r;

  always_comb begin
    state_nxt   = state_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    fill_nxt    = fill_r;
    rt_nxt      = rt_r;
    n_nxt       = n_r;
    pend_v_nxt  = pend_v_r;
    pend_id_nxt = pend_id_r;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    emit        = 1'b0;
    emit_id     = pend_id_r;
    emit_kind   = tevq_pkg::KIND_RELEASE;
    emit_last   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (cmd_valid) begin
          unique case (cmd.op)
            tevq_pkg::OP_ADD: begin
              if (fill_r == CW'(DEPTH)) begin
                if (out_free) begin
                  emit      = 1'b1;
                  emit_id   = cmd.id;
                  emit_kind = tevq_pkg::KIND_REJECT;
                  emit_last = 1'b1;
                  cmd_pop   = 1'b1;
                end
              end else begin
                ram_we   = 1'b1;
                tail_nxt = (tail_r == AW'(DEPTH - 1)) ? '0 : tail_r + AW'(1);
                fill_nxt = fill_r + CW'(1);
                cmd_pop  = 1'b1;
              end
            end
            tevq_pkg::OP_START: begin
              rt_nxt  = '0;
              cmd_pop = 1'b1;
            end
            tevq_pkg::OP_TICK: begin
              rt_nxt     = tick_sum[31] ? '1 : tick_sum[30:0];
              n_nxt      = '0;
              pend_v_nxt = 1'b0;
              cmd_pop    = 1'b1;
              state_nxt  = ST_READ;
            end
            default: begin
              cmd_pop = 1'b1;
            end
          endcase
        end
      end
      ST_READ: begin
        if ((fill_r == '0) || (n_r == NW'(tevq_pkg::MAX_OUT))) begin
          state_nxt = ST_FINISH;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!time_lt) begin
          state_nxt = ST_FINISH;
        end else if (rd_time[31]) begin
          head_nxt  = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          fill_nxt  = fill_r - CW'(1);
          state_nxt = ST_READ;
        end else if (!pend_v_r || out_free) begin
          head_nxt    = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
          fill_nxt    = fill_r - CW'(1);
          emit        = pend_v_r;
          pend_v_nxt  = 1'b1;
          pend_id_nxt = rd_id;
          n_nxt       = n_r + NW'(1);
          state_nxt   = ST_READ;
        end
      end
      ST_FINISH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          pend_v_nxt = 1'b0;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      head_r      <= '0;
      tail_r      <= '0;
      fill_r      <= '0;
      rt_r        <= '0;
      n_r         <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      fill_r      <= fill_nxt;
      rt_r        <= rt_nxt;
      n_r         <= n_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r <= pend_id_nxt;
    if (emit) begin
      out_id_r   <= emit_id;
      out_kind_r <= emit_kind;
      out_last_r <= emit_last;
    end
  end

endmodule

// ----- src/timed_event_release_queue_top.sv -----
// top level of the timed event release queue
// A FIFO of up to DEPTH events (16-bit handle, signed Q24.8 start time) in request
// order. An add request appends an event or, when full, answers with one rejected
// result (tuser 1, tlast 1). A start request zeroes the running time. A tick request
// adds the elapsed time (saturating at 0x7FFFFFFF) and pops every front event whose
// start time is strictly below the running time, up to 16 releases per tick; events
// with a negative start time are dropped without a result, and the final release
// carries tlast. A two-entry command queue sits between request intake and the
// executing back end, so requests are taken while the back end is busy. In the back
// end, add and start are handled in the idle state; a tick steps through a read and a
// check state per front entry examined, the read state covering the registered
// read port of the event memory, and ends in a finish state; results leave through
// an output register and the sequencer waits while it is occupied.
module timed_event_release_queue_top #(
  parameter int unsigned DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // event_id, start_time, elapsed, zero pad
  input  logic [1:0]  in_tuser,   // req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // released_id
  output logic        out_tlast,
  output logic [0:0]  out_tuser   // kind
);

  logic           cmd_valid;
  logic           cmd_pop;
  tevq_pkg::cmd_t cmd;

  tevq_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata (in_tdata),
    .in_tuser (in_tuser),
    .cmd_valid(cmd_valid),
    .cmd      (cmd),
    .cmd_pop  (cmd_pop)
  );

  tevq_back #(
    .DEPTH(DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

endmodule

// ----- src/tevq_checker.sv -----
// port level checks of the timed event release queue and their bind
module tevq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [0:0]  out_tuser
);

  // stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // stalled result keeps its content
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=>
      $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled result changed");

  // a rejected add is always a single result
  a_reject_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast)
    else $error("rejected add without tlast");

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

endmodule

bind timed_event_release_queue_top tevq_checker u_tevq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);

// ----- tb/sv/tb_timed_event_release_queue_top.sv -----
// testbench for the timed event release queue: random and directed requests, scoreboard check
`timescale 1ns / 1ps

module tb_timed_event_release_queue_top;

  localparam logic [1:0] REQ_UNUSED = 2'd3;
  localparam int unsigned CLK_HALF = 6;
  localparam int unsigned RANDOM_REQUESTS = 85;

  typedef struct packed {
    logic [15:0] id;
    logic        kind;
    logic        last;
  } release_t;

  class release_scoreboard;
    localparam int SLOTS = 16;

    logic [15:0] slot_id[SLOTS];
    logic [31:0] slot_time[SLOTS];
    int          head;
    int          tail;
    int          fill;
    logic [31:0] clock_now;
    release_t    due[$];

    function new();
      head = 0;
      tail = 0;
      fill = 0;
      clock_now = '0;
    endfunction

    function int pending();
      return due.size();
    endfunction

    function void note_request(logic [1:0] req, logic [15:0] id, logic [31:0] st,
                               logic [30:0] el);
      logic [32:0] sum;
      release_t    r;
      int          n;
      int          t;
      int          now_i;
      unique case (req)
        tevq_pkg::REQ_ADD: begin
          if (fill >= SLOTS) begin
            r = '{id: id, kind: tevq_pkg::KIND_REJECT, last: 1'b1};
            due = {due, r};
          end else begin
            slot_id[tail] = id;
            slot_time[tail] = st;
            tail = (tail + 1) % SLOTS;
            fill++;
          end
        end
        tevq_pkg::REQ_START: clock_now = '0;
        tevq_pkg::REQ_TICK: begin
          sum = {1'b0, clock_now} + {2'b00, el};
          clock_now = (sum > 33'h07FFFFFFF) ? 32'h7FFFFFFF : sum[31:0];
          now_i = clock_now;
          n = 0;
          while (fill > 0 && n < int'(tevq_pkg::MAX_OUT)) begin
            t = slot_time[head];
            if (!(t < now_i)) break;
            r = '{id: slot_id[head], kind: tevq_pkg::KIND_RELEASE, last: 1'b0};
            head = (head + 1) % SLOTS;
            fill--;
            if (t < 0) continue;
            due = {due, r};
            n++;
          end
          if (n > 0) begin
            r = due[due.size() - 1];
            r.last = 1'b1;
            due[due.size() - 1] = r;
          end
        end
        default: ;
      endcase
    endfunction

    function bit check_result(release_t got, output string msg);
      release_t exp;
      msg = "";
      if (due.size() == 0) begin
        msg = $sformatf("unexpected result id %h kind %0d last %0d", got.id, got.kind,
                        got.last);
        return 1'b0;
      end
      exp = due.pop_front();
      if (got.id !== exp.id)
        msg = {msg, $sformatf(" id got %h exp %h", got.id, exp.id)};
      if (got.kind !== exp.kind)
        msg = {msg, $sformatf(" kind got %0d exp %0d", got.kind, exp.kind)};
      if (got.last !== exp.last)
        msg = {msg, $sformatf(" last got %0d exp %0d", got.last, exp.last)};
      return msg.len() == 0;
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;
  logic [0:0]  out_tuser;

  release_scoreboard sb;
  int  errors;
  bit  steady;

  timed_event_release_queue_top u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial clk = 1'b0;
  always #(CLK_HALF) clk = ~clk;

  task automatic report(string msg);
    $display("%0t mismatch:%s", $time, msg);
    errors++;
  endtask

  // one request, held until accepted; valid stays high for a back-to-back request
  task automatic send(logic [1:0] req, logic [15:0] id, logic [31:0] st, logic [30:0] el);
    @(negedge clk);
    while (!steady && $urandom_range(0, 99) < 10) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {1'b0, el, st, id};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(req, id, st, el);
  endtask

  task automatic drain();
    int waited;
    waited = 0;
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0 && waited < 50000) begin
      @(posedge clk);
      waited++;
    end
  endtask

  always @(negedge clk) begin
    out_tready <= rst_n && (steady || $urandom_range(0, 99) >= 10);
  end

  always @(posedge clk) begin
    string    msg;
    release_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = '{id: out_tdata, kind: out_tuser[0], last: out_tlast};
      if (!sb.check_result(got, msg)) report(msg);
    end
  end

  initial begin
    #2ms;
    $display("simulation failed");
    $finish;
  end

  initial begin
    int          counted;
    int          pick;
    logic [32:0] near;
    logic [31:0] st;
    sb = new();
    errors = 0;
    steady = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = tevq_pkg::REQ_ADD;
    out_tready = 1'b0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    // tick on empty, drop of negative time, equal time held back
    send(tevq_pkg::REQ_TICK, 16'h0000, 32'h0, 31'h0);
    send(tevq_pkg::REQ_ADD, 16'h0000, 32'h80000000, 31'h0);
    send(tevq_pkg::REQ_ADD, 16'hFFFF, 32'h0, 31'h0);
    send(tevq_pkg::REQ_TICK, 16'h0000, 32'h0, 31'h0);
    send(tevq_pkg::REQ_TICK, 16'h0000, 32'h0, 31'h1);
    // saturation of the running time
    send(tevq_pkg::REQ_ADD, 16'h1234, 32'h7FFFFFFE, 31'h0);
    send(tevq_pkg::REQ_TICK, 16'h0000, 32'h0, 31'h7FFFFFFF);
    send(tevq_pkg::REQ_START, 16'hFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
    send(REQ_UNUSED, 16'hA5A5, 32'h00000010, 31'h00000010);
    // fill to full, reject one, release the whole queue
    for (int i = 0; i < 16; i++)
      send(tevq_pkg::REQ_ADD, 16'(16'h5A00 + i), (i % 5 == 3) ? -32'(i) : 32'(i * 37),
           31'h0);
    send(tevq_pkg::REQ_ADD, 16'hBEEF, 32'h0, 31'h0);
    send(tevq_pkg::REQ_TICK, 16'h0000, 32'h0, 31'h7FFFFFFF);
    send(tevq_pkg::REQ_START, 16'h0000, 32'h0, 31'h0);

    drain();

    counted = 0;
    while (counted < RANDOM_REQUESTS) begin
      steady = (counted >= 40 && counted < 75);
      if (counted == 80) drain();
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        pick = $urandom_range(0, 99);
        near = {1'b0, sb.clock_now} + 33'($urandom_range(0, 600));
        if (pick < 80)
          st = (near > 33'h07FFFFFFE) ? 32'h7FFFFFFE : near[31:0];
        else if (pick < 93)
          st = -32'($urandom_range(1, 1000));
        else
          st = $urandom();
        send(tevq_pkg::REQ_ADD, 16'($urandom()), st, 31'($urandom()));
        counted++;
      end else if (pick < 84) begin
        send(tevq_pkg::REQ_TICK, 16'($urandom()), $urandom(), 31'($urandom_range(0, 300)));
        counted++;
      end else if (pick < 90) begin
        send(tevq_pkg::REQ_START, 16'($urandom()), $urandom(), 31'($urandom()));
        counted++;
      end else if (pick < 94) begin
        send(REQ_UNUSED, 16'($urandom()), $urandom(), 31'($urandom()));
      end else begin
        send(tevq_pkg::REQ_TICK, 16'($urandom()), $urandom(), 31'($urandom()));
        counted++;
      end
    end
    steady = 1'b0;
    @(negedge clk);
    in_tvalid <= 1'b0;

    drain();
    repeat (80) @(posedge clk);
    if (sb.pending() != 0)
      report($sformatf(" %0d expected results never arrived", sb.pending()));
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
